// File: hw/rtl/vag_dec_pkg.sv
// ----------------------------------------------------------------------------
// VAG ADPCM frame decoder package
// Shared types, codes and the prediction filter table.
// ----------------------------------------------------------------------------
package vag_dec_pkg;

  localparam logic OP_STREAM = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [3:0] POS_HEADER = 4'd0;
  localparam logic [3:0] POS_FLAGS  = 4'd1;

  typedef struct packed {
    logic signed [7:0] c0;
    logic signed [7:0] c1;
  } coef_t;

  typedef struct packed {
    logic        [3:0]  nibble;
    logic        [3:0]  shift_amt;
    logic        [3:0]  filter_sel;
    logic signed [15:0] newest;
    logic signed [15:0] older;
  } calc_in_t;

  function automatic coef_t coef_lookup(input logic [3:0] sel);
    coef_t c;
    unique case (sel)
      4'd0:  c = '{8'sd0,   8'sd0};
      4'd1:  c = '{8'sd60,  8'sd0};
      4'd2:  c = '{8'sd115, -8'sd52};
      4'd3:  c = '{8'sd98,  -8'sd55};
      4'd4:  c = '{8'sd122, -8'sd60};
      4'd5:  c = '{8'sd30,  8'sd0};
      4'd6:  c = '{8'sd57,  -8'sd26};
      4'd7:  c = '{8'sd49,  -8'sd27};
      4'd8:  c = '{8'sd61,  -8'sd30};
      4'd9:  c = '{8'sd15,  8'sd0};
      4'd10: c = '{8'sd29,  -8'sd13};
      4'd11: c = '{8'sd24,  -8'sd14};
      4'd12: c = '{8'sd30,  -8'sd15};
      4'd13: c = '{8'sd32,  -8'sd60};
      4'd14: c = '{8'sd15,  -8'sd60};
      4'd15: c = '{8'sd7,   -8'sd60};
      default: c = '{8'sd0, 8'sd0};
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/vag_dec_sample.sv
// ----------------------------------------------------------------------------
// VAG ADPCM nibble decode
// Scales one nibble, adds the two-tap prediction and saturates to int16.
// ----------------------------------------------------------------------------
module vag_dec_sample (
  input  vag_dec_pkg::calc_in_t calc_in,
  output logic signed [15:0]    sample
);
  import vag_dec_pkg::*;

  coef_t              coef;
  logic signed [23:0] prod0;
  logic signed [23:0] prod1;
  logic signed [24:0] pred_sum;
  logic signed [24:0] pred_adj;
  logic signed [18:0] pred;
  logic        [15:0] nib_word;
  logic signed [15:0] scaled;
  logic signed [19:0] total;

  assign coef     = coef_lookup(calc_in.filter_sel);
  assign prod0    = $signed(calc_in.newest) * $signed(coef.c0);
  assign prod1    = $signed(calc_in.older) * $signed(coef.c1);
  assign pred_sum = 25'(prod0) + 25'(prod1);
  // divide by 64 rounding toward zero
  assign pred_adj = pred_sum[24] ? (pred_sum + 25'sd63) : pred_sum;
  assign pred     = pred_adj[24:6];

  assign nib_word = {calc_in.nibble, 12'd0};
  assign scaled   = $signed(nib_word) >>> calc_in.shift_amt;
  assign total    = 20'(scaled) + 20'(pred);

  always_comb begin
    if (total > 20'sd32767) begin
      sample = 16'sh7fff;
    end else if (total < -20'sd32768) begin
      sample = 16'sh8000;
    end else begin
      sample = total[15:0];
    end
  end

endmodule

// File: hw/rtl/vag_adpcm_frame_decoder.sv
// ----------------------------------------------------------------------------
// VAG ADPCM frame decoder
// Decodes a 16-byte-frame ADPCM byte stream into saturated 16-bit samples.
// ----------------------------------------------------------------------------
// Each accepted byte sits in an input register and is worked off one nibble
// per cycle, while the output side takes transfers, through a single
// multiply-add prediction path into the output register. A data byte yields
// two samples (low nibble first, tlast on the second) and stays held until
// its high nibble is decoded; header, flags and clear items finish when stepped.
// A new byte is taken in the cycle the previous one finishes, so the input
// does not pause between bytes while the output side keeps taking transfers.
module vag_adpcm_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_value
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // sample
  output logic        m_axis_tlast,   // last_of_run
  output logic        m_axis_tuser    // halted
);
  import vag_dec_pkg::*;

  logic               item_valid;
  logic               item_op;
  logic [7:0]         item_byte;
  logic               phase;
  logic signed [15:0] hist_newest;
  logic signed [15:0] hist_older;
  logic [3:0]         frame_pos;
  logic [3:0]         shift_amt;
  logic [3:0]         filter_sel;
  logic               stopped;

  logic               can_emit;
  logic               needs_out;
  logic               is_data;
  logic               is_clear;
  logic               is_header;
  logic               is_flags;
  logic               halt_out;
  logic               step;
  logic               done;
  calc_in_t           calc_in;
  logic signed [15:0] calc_sample;

  assign can_emit = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    is_clear  = 1'b0;
    is_header = 1'b0;
    is_flags  = 1'b0;
    is_data   = 1'b0;
    halt_out  = 1'b0;
    priority if (item_op == OP_CLEAR) begin
      is_clear = 1'b1;
    end else if (stopped) begin
      halt_out = 1'b1;
    end else if (frame_pos == POS_HEADER) begin
      is_header = 1'b1;
    end else if (frame_pos == POS_FLAGS) begin
      is_flags = 1'b1;
      halt_out = item_byte[0];
    end else begin
      is_data = 1'b1;
    end
  end

  assign needs_out     = halt_out || is_data;
  assign step          = item_valid && (!needs_out || can_emit);
  assign done          = step && (!is_data || phase);
  assign s_axis_tready = !item_valid || done;

  assign calc_in.nibble     = phase ? item_byte[7:4] : item_byte[3:0];
  assign calc_in.shift_amt  = shift_amt;
  assign calc_in.filter_sel = filter_sel;
  assign calc_in.newest     = hist_newest;
  assign calc_in.older      = hist_older;

  vag_dec_sample u_sample (
    .calc_in (calc_in),
    .sample  (calc_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid    <= 1'b0;
      phase         <= 1'b0;
      hist_newest   <= '0;
      hist_older    <= '0;
      frame_pos     <= POS_HEADER;
      shift_amt     <= '0;
      filter_sel    <= '0;
      stopped       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        item_valid <= s_axis_tvalid;
      end
      if (step && is_data) begin
        phase <= !phase;
      end
      if (step) begin
        if (is_clear) begin
          hist_newest <= '0;
          hist_older  <= '0;
          frame_pos   <= POS_HEADER;
          shift_amt   <= '0;
          filter_sel  <= '0;
          stopped     <= 1'b0;
        end else if (is_header) begin
          shift_amt  <= item_byte[3:0];
          filter_sel <= item_byte[7:4];
          frame_pos  <= POS_FLAGS;
        end else if (is_flags) begin
          if (halt_out) begin
            stopped <= 1'b1;
          end else begin
            frame_pos <= frame_pos + 4'd1;
          end
        end else if (is_data) begin
          hist_older  <= hist_newest;
          hist_newest <= calc_sample;
          if (phase) begin
            frame_pos <= frame_pos + 4'd1;
          end
        end
      end
      if (step && needs_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_op   <= s_axis_tuser;
      item_byte <= s_axis_tdata;
    end
    if (step && needs_out) begin
      m_axis_tdata <= halt_out ? 16'd0 : calc_sample;
      m_axis_tlast <= halt_out || phase;
      m_axis_tuser <= halt_out;
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0 && m_axis_tlast)
    else $error("halted transfer carries a nonzero sample or no tlast");

  a_phase_item: assert property (@(posedge clk) disable iff (rst)
    phase |-> item_valid && item_op == OP_STREAM)
    else $error("high nibble pending without a held data byte");

  a_low_then_high: assert property (@(posedge clk) disable iff (rst)
    step && is_data && !phase |=> phase && item_valid)
    else $error("low nibble not followed by high nibble");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped && !(step && is_clear) |=> stopped)
    else $error("halt dropped without a clear");

  a_no_accept_mid: assert property (@(posedge clk) disable iff (rst)
    item_valid && is_data && !phase |-> !s_axis_tready)
    else $error("input taken before both nibbles were decoded");
`endif

endmodule

// File: tb/vag_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VAG ADPCM decoder stream checker
// Watches the byte and sample streams and predicts each sample from the
// accepted bytes. Every sample transfer is compared field by field with the
// oldest prediction. The failure count and the number of outstanding
// predictions go to the testbench top.
// ----------------------------------------------------------------------------
module vag_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_value
  input  logic        s_axis_tuser,   // operation
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // sample
  input  logic        m_axis_tlast,   // last_of_run
  input  logic        m_axis_tuser,   // halted
  output int          errors,
  output int          pending,
  output int          checked
);
  import vag_dec_pkg::*;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               halted;
  } pcm_result_t;

  pcm_result_t        sample_q[$];

  logic signed [15:0] hist_new;
  logic signed [15:0] hist_old;
  logic [3:0]         frame_pos;
  logic [3:0]         shift_amt;
  logic [3:0]         filter_sel;
  logic               halted_st;

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  function automatic int tap_coef(logic [3:0] sel, bit older_tap);
    int c0, c1;
    case (sel)
      4'd0:    begin c0 = 0;   c1 = 0;   end
      4'd1:    begin c0 = 60;  c1 = 0;   end
      4'd2:    begin c0 = 115; c1 = -52; end
      4'd3:    begin c0 = 98;  c1 = -55; end
      4'd4:    begin c0 = 122; c1 = -60; end
      4'd5:    begin c0 = 30;  c1 = 0;   end
      4'd6:    begin c0 = 57;  c1 = -26; end
      4'd7:    begin c0 = 49;  c1 = -27; end
      4'd8:    begin c0 = 61;  c1 = -30; end
      4'd9:    begin c0 = 15;  c1 = 0;   end
      4'd10:   begin c0 = 29;  c1 = -13; end
      4'd11:   begin c0 = 24;  c1 = -14; end
      4'd12:   begin c0 = 30;  c1 = -15; end
      4'd13:   begin c0 = 32;  c1 = -60; end
      4'd14:   begin c0 = 15;  c1 = -60; end
      default: begin c0 = 7;   c1 = -60; end
    endcase
    return older_tap ? c1 : c0;
  endfunction

  function automatic logic signed [15:0] pcm_from_nibble(
    logic [3:0] nib, logic [3:0] shf, logic [3:0] sel,
    logic signed [15:0] newest, logic signed [15:0] older);
    int base, acc, pred;
    base = nib[3] ? int'(nib) - 16 : int'(nib);
    acc  = (base * 4096) >>> shf;
    pred = (int'(newest) * tap_coef(sel, 1'b0) + int'(older) * tap_coef(sel, 1'b1)) / 64;
    acc  = acc + pred;
    if (acc > 32767)  acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc[15:0];
  endfunction

  task automatic push_result(logic signed [15:0] smp, logic lst, logic hlt);
    pcm_result_t r;
    r.sample = smp;
    r.last   = lst;
    r.halted = hlt;
    sample_q.push_back(r);
  endtask

  task automatic predict_byte(logic op, logic [7:0] b);
    logic signed [15:0] s0, s1;
    if (op == OP_CLEAR) begin
      hist_new   = '0;
      hist_old   = '0;
      frame_pos  = POS_HEADER;
      shift_amt  = '0;
      filter_sel = '0;
      halted_st  = 1'b0;
    end else if (halted_st) begin
      push_result(16'sd0, 1'b1, 1'b1);
    end else if (frame_pos == POS_HEADER) begin
      shift_amt  = b[3:0];
      filter_sel = b[7:4];
      frame_pos  = POS_FLAGS;
    end else if (frame_pos == POS_FLAGS) begin
      if (b[0]) begin
        halted_st = 1'b1;
        push_result(16'sd0, 1'b1, 1'b1);
      end else begin
        frame_pos = POS_FLAGS + 4'd1;
      end
    end else begin
      s0       = pcm_from_nibble(b[3:0], shift_amt, filter_sel, hist_new, hist_old);
      hist_old = hist_new;
      hist_new = s0;
      s1       = pcm_from_nibble(b[7:4], shift_amt, filter_sel, hist_new, hist_old);
      hist_old = hist_new;
      hist_new = s1;
      push_result(s0, 1'b0, 1'b0);
      push_result(s1, 1'b1, 1'b0);
      frame_pos = frame_pos + 4'd1;
    end
  endtask

  always @(posedge clk) begin : watch
    pcm_result_t got, want;
    if (rst) begin
      sample_q.delete();
      hist_new   = '0;
      hist_old   = '0;
      frame_pos  = POS_HEADER;
      shift_amt  = '0;
      filter_sel = '0;
      halted_st  = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.sample = m_axis_tdata;
        got.last   = m_axis_tlast;
        got.halted = m_axis_tuser;
        checked++;
        if (sample_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected sample transfer: sample %0d last %0b halted %0b",
                   $time, got.sample, got.last, got.halted);
        end else begin
          want = sample_q.pop_front();
          if (got.sample !== want.sample) begin
            errors++;
            $display("%0t: sample mismatch: expected %0d, actual %0d",
                     $time, want.sample, got.sample);
          end
          if (got.last !== want.last) begin
            errors++;
            $display("%0t: tlast mismatch: expected %0b, actual %0b",
                     $time, want.last, got.last);
          end
          if (got.halted !== want.halted) begin
            errors++;
            $display("%0t: halted mismatch: expected %0b, actual %0b",
                     $time, want.halted, got.halted);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_byte(s_axis_tuser, s_axis_tdata);
    end
    pending = sample_q.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VAG ADPCM frame decoder testbench
// Drives directed frames (filter and shift extremes, saturation, loop halt,
// clear) and then random well-formed, halting, truncated and noisy frames
// with random idling on both streams. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb_top;
  import vag_dec_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // byte_value
  logic        s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // sample
  logic        m_axis_tlast;   // last_of_run
  logic        m_axis_tuser;   // halted

  bit no_idle;
  int errors, pending, checked;
  int sent, frames, halts, clears;

  vag_adpcm_frame_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  vag_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 29);
  end

  initial begin
    #3_000_000;
    $display("Timeout: %0d samples still outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_byte(logic op, logic [7:0] b);
    logic ready_seen;
    while (!no_idle && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= op;
    forever begin
      @(negedge clk);
      ready_seen = s_axis_tready;
      @(posedge clk);
      if (ready_seen) break;
    end
    sent++;
    if (op == OP_CLEAR) clears++;
  endtask

  // hold the byte stream until every sample has drained
  task automatic drain_samples();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_frame(logic [7:0] hdr, logic [7:0] flg, int n_data);
    send_byte(OP_STREAM, hdr);
    send_byte(OP_STREAM, flg);
    repeat (n_data) send_byte(OP_STREAM, 8'($urandom));
  endtask

  initial begin : stimulus
    int r, n, wait_cnt, fails, next_drain;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_STREAM;
    m_axis_tready = 1'b0;
    no_idle       = 1'b0;
    sent = 0; frames = 0; halts = 0; clears = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: filter 4 at shift 0 drives both saturation limits
    send_byte(OP_CLEAR, 8'h00);
    send_byte(OP_STREAM, 8'h40);
    send_byte(OP_STREAM, 8'hFE);
    repeat (6) send_byte(OP_STREAM, 8'h77);
    repeat (4) send_byte(OP_STREAM, 8'h88);
    send_byte(OP_STREAM, 8'h00);
    send_byte(OP_STREAM, 8'hFF);
    send_byte(OP_STREAM, 8'h80);
    send_byte(OP_STREAM, 8'h08);
    frames++;
    // filter 15, shift 15, loop flag halts; stream byte while halted
    send_byte(OP_STREAM, 8'hFF);
    send_byte(OP_STREAM, 8'h01);
    send_byte(OP_STREAM, 8'h55);
    halts++;
    send_byte(OP_CLEAR, 8'hAB);
    send_byte(OP_STREAM, 8'h0F);
    send_byte(OP_STREAM, 8'h00);
    send_byte(OP_STREAM, 8'h12);
    drain_samples();
    send_byte(OP_CLEAR, 8'hFF);

    next_drain = sent + 100;
    while (sent < 740) begin
      no_idle = (sent >= 300 && sent < 420);
      r = $urandom_range(99);
      if (r < 70) begin
        send_frame(8'($urandom), 8'($urandom) & 8'hFE, 14);
        frames++;
      end else if (r < 80) begin
        send_frame(8'($urandom), 8'($urandom) | 8'h01, $urandom_range(3));
        halts++;
        send_byte(OP_CLEAR, 8'($urandom));
      end else if (r < 90) begin
        send_frame(8'($urandom), 8'($urandom) & 8'hFE, $urandom_range(13, 1));
        send_byte(OP_CLEAR, 8'($urandom));
      end else begin
        n = $urandom_range(4, 1);
        repeat (n) send_byte(1'($urandom), 8'($urandom));
        send_byte(OP_CLEAR, 8'($urandom));
      end
      if (sent >= next_drain) begin
        drain_samples();
        next_drain = sent + 100 + $urandom_range(100);
      end
    end

    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;
    for (wait_cnt = 0; pending != 0 && wait_cnt < 5000; wait_cnt++) @(negedge clk);
    repeat (20) @(posedge clk);
    fails = errors;
    if (pending != 0) begin
      fails++;
      $display("%0t: %0d expected samples never arrived", $time, pending);
    end
    $display("Covered %0d byte transfers: %0d full frames, %0d loop halts, %0d clears",
             sent, frames, halts, clears);
    $display("%0d sample transfers compared, %0d failures", checked, fails);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
